### rtl/bmpuck_pkg.sv
// ----------------------------------------------------------------------------
// bmpuck_pkg
// Shared codes, widths and defaults of the BMP pixel unpacker with color key.
// ----------------------------------------------------------------------------
package bmpuck_pkg;

   // Defaults of the top-level parameters
   localparam int PAL_DEPTH_DEF = 256;
   localparam int MAX_DIM_DEF   = 1024;

   // Field widths
   localparam int COLOR_W = 32;
   localparam int XY_W    = 11;
   localparam int CMP_W   = 12;   // holds a dimension up to 2048 and count + 1

   // Item kinds on the input channel
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_PIXEL   = 1'b1;

   // Pixel formats
   localparam logic [2:0] FMT_4BPP  = 3'd0;
   localparam logic [2:0] FMT_8BPP  = 3'd1;
   localparam logic [2:0] FMT_16BPP = 3'd2;
   localparam logic [2:0] FMT_24BPP = 3'd3;
   localparam logic [2:0] FMT_32BPP = 3'd4;

   // Color key modes
   localparam logic [1:0] KEY_DRAW_ALL = 2'd0;
   localparam logic [1:0] KEY_SKIP     = 2'd1;
   localparam logic [1:0] KEY_REPLACE  = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_PIXEL_FORMAT     = 3'd0;
   localparam logic [2:0] REG_KEY_MODE         = 3'd1;
   localparam logic [2:0] REG_KEY_COLOR        = 3'd2;
   localparam logic [2:0] REG_SUBSTITUTE_COLOR = 3'd3;
   localparam logic [2:0] REG_ORIGIN_X         = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Y         = 3'd5;
   localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd6;
   localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd7;

   // Register reset values
   localparam logic [2:0]  PIXEL_FORMAT_RST = FMT_16BPP;
   localparam logic [10:0] IMAGE_DIM_RST    = 11'd1;

endpackage

### rtl/bmp_pixel_unpack_color_key.sv
// ----------------------------------------------------------------------------
// bmp_pixel_unpack_color_key
// Decodes BMP pixel-data bytes into keyed screen pixels with their positions.
// ----------------------------------------------------------------------------
// An input item is either a palette load (tuser = 0) or one byte of the pixel
// data area (tuser = 1). Palette loads never enter the pixel stage, and bytes
// in 8, 16, 24 and 32 bpp leave it once the result register is free or being
// emptied, so an item can enter every cycle while that holds; a 4bpp byte
// holds the pixel stage for both of its pixels, because the single result
// register sends out one pixel per cycle while rsp_tready is high. The palette
// reads and the byte are registered as the byte is accepted, and the result
// register is loaded from them, the pixels of a 4bpp byte in turn. The palette is a
// PALETTE_DEPTH x 32 memory with one write and two registered reads; its
// entries are undefined until loaded and it needs no clearing pass. Columns
// count up from origin_x, rows start at origin_y + image_height and count
// down; a pixel dropped by the color key still advances the position, and
// tlast marks the last position of the image, after which the next byte
// starts a new image. Registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module bmp_pixel_unpack_color_key
   import bmpuck_pkg::*;
#(
   parameter int PALETTE_DEPTH = PAL_DEPTH_DEF,
   parameter int MAX_DIM       = MAX_DIM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // palette_slot[7:0], palette_word[39:8], data_byte[47:40]
   input  logic        req_tuser,   // command
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pixel_color[31:0], pixel_x[42:32], pixel_y[53:43], zero
   output logic        rsp_tlast,   // last_pixel
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int              PAL_AW    = $clog2(PALETTE_DEPTH);
   localparam logic [8:0]      PAL_LIMIT = 9'(PALETTE_DEPTH);
   localparam logic [CMP_W-1:0] DIM_LIMIT = CMP_W'(MAX_DIM);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [2:0]         pixel_format_ff;
   logic [1:0]         key_mode_ff;
   logic [COLOR_W-1:0] key_color_ff;
   logic [COLOR_W-1:0] substitute_color_ff;
   logic [9:0]         origin_x_ff;
   logic [9:0]         origin_y_ff;
   logic [10:0]        image_width_ff;
   logic [10:0]        image_height_ff;

   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff     <= PIXEL_FORMAT_RST;
         key_mode_ff         <= KEY_DRAW_ALL;
         key_color_ff        <= '0;
         substitute_color_ff <= '0;
         origin_x_ff         <= '0;
         origin_y_ff         <= '0;
         image_width_ff      <= IMAGE_DIM_RST;
         image_height_ff     <= IMAGE_DIM_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_PIXEL_FORMAT:     pixel_format_ff     <= csr_pwdata[2:0];
            REG_KEY_MODE:         key_mode_ff         <= csr_pwdata[1:0];
            REG_KEY_COLOR:        key_color_ff        <= csr_pwdata;
            REG_SUBSTITUTE_COLOR: substitute_color_ff <= csr_pwdata;
            REG_ORIGIN_X:         origin_x_ff         <= csr_pwdata[9:0];
            REG_ORIGIN_Y:         origin_y_ff         <= csr_pwdata[9:0];
            REG_IMAGE_WIDTH:      image_width_ff      <= csr_pwdata[10:0];
            REG_IMAGE_HEIGHT:     image_height_ff     <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_PIXEL_FORMAT:     csr_prdata = {29'd0, pixel_format_ff};
         REG_KEY_MODE:         csr_prdata = {30'd0, key_mode_ff};
         REG_KEY_COLOR:        csr_prdata = key_color_ff;
         REG_SUBSTITUTE_COLOR: csr_prdata = substitute_color_ff;
         REG_ORIGIN_X:         csr_prdata = {22'd0, origin_x_ff};
         REG_ORIGIN_Y:         csr_prdata = {22'd0, origin_y_ff};
         REG_IMAGE_WIDTH:      csr_prdata = {21'd0, image_width_ff};
         REG_IMAGE_HEIGHT:     csr_prdata = {21'd0, image_height_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Input side: palette writes go straight to memory, data bytes start the
   // two palette reads and load the pixel stage.
   // ------------------------------------------------------------------------
   logic [7:0]         req_slot;
   logic [COLOR_W-1:0] req_word;
   logic [7:0]         req_byte;
   logic               req_accept;
   logic               req_oob;
   logic               slot_ok;
   logic [PAL_AW-1:0]  rd_addr_hi;
   logic [PAL_AW-1:0]  rd_addr_lo;

   assign req_slot   = req_tdata[7:0];
   assign req_word   = req_tdata[39:8];
   assign req_byte   = req_tdata[47:40];
   assign req_accept = req_tvalid & req_tready;
   assign slot_ok    = ({1'b0, req_slot} < PAL_LIMIT);
   assign req_oob    = ({1'b0, req_byte} >= PAL_LIMIT);

   // In 4bpp the two nibbles read two entries; otherwise the whole byte is
   // the index, parked at entry 0 when it lies beyond the palette.
   always_comb begin
      if (pixel_format_ff == FMT_4BPP) begin
         rd_addr_hi = PAL_AW'(req_byte[7:4]);
      end else if (req_oob) begin
         rd_addr_hi = '0;
      end else begin
         rd_addr_hi = req_byte[PAL_AW-1:0];
      end
      rd_addr_lo = PAL_AW'(req_byte[3:0]);
   end

   logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rd_hi_ff;
   logic [COLOR_W-1:0] rd_lo_ff;

   always_ff @(posedge clock) begin
      if (req_accept && req_tuser == CMD_PALETTE && slot_ok) begin
         palette_mem[req_slot[PAL_AW-1:0]] <= req_word;
      end
      if (req_accept && req_tuser == CMD_PIXEL) begin
         rd_hi_ff <= palette_mem[rd_addr_hi];
         rd_lo_ff <= palette_mem[rd_addr_lo];
      end
   end

   // Pixel stage payload
   logic [7:0] s1_byte_ff;
   logic       s1_oob_ff;

   always_ff @(posedge clock) begin
      if (req_accept && req_tuser == CMD_PIXEL) begin
         s1_byte_ff <= req_byte;
         s1_oob_ff  <= req_oob;
      end
   end

   // ------------------------------------------------------------------------
   // Pixel stage: decode, position, color key
   // ------------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   logic              nibble_ff, nibble_in;
   logic [23:0]       gather_ff, gather_in;
   logic [1:0]        idx_ff, idx_in;
   logic [XY_W-1:0]   col_ff, col_in;
   logic [XY_W-1:0]   row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [XY_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic              rsp_last_ff;

   logic [CMP_W-1:0]  w_clamp, h_clamp;
   logic [CMP_W-1:0]  col_inc, row_inc;
   logic              col_wrap, row_wrap, is_last;
   logic [XY_W-1:0]   pix_x, pix_y;

   logic              adv, emit, item_end, emit_fire, drop, rsp_load;
   logic [COLOR_W-1:0] raw_color, out_color;
   logic [23:0]       gath_new;
   logic [1:0]        idx_next;
   logic [2:0]        need;
   logic              gather_fmt, complete;
   logic [7:0]        g0, g1;

   // Zero means one, anything above MAX_DIM means MAX_DIM
   always_comb begin
      if (image_width_ff == '0) begin
         w_clamp = CMP_W'(1);
      end else if ({1'b0, image_width_ff} > DIM_LIMIT) begin
         w_clamp = DIM_LIMIT;
      end else begin
         w_clamp = {1'b0, image_width_ff};
      end
      if (image_height_ff == '0) begin
         h_clamp = CMP_W'(1);
      end else if ({1'b0, image_height_ff} > DIM_LIMIT) begin
         h_clamp = DIM_LIMIT;
      end else begin
         h_clamp = {1'b0, image_height_ff};
      end
   end

   assign col_inc  = {1'b0, col_ff} + CMP_W'(1);
   assign row_inc  = {1'b0, row_ff} + CMP_W'(1);
   assign col_wrap = (col_inc >= w_clamp);
   assign row_wrap = (row_inc >= h_clamp);
   assign is_last  = col_wrap & row_wrap;
   assign pix_x    = {1'b0, origin_x_ff} + col_ff;
   assign pix_y    = {1'b0, origin_y_ff} + h_clamp[XY_W-1:0] - row_ff;

   // Advance whenever the result register is free or being emptied
   assign adv = s1_valid_ff & (~rsp_valid_ff | rsp_tready);

   // Byte gathering for the direct-color formats
   always_comb begin
      gath_new = gather_ff;
      case (idx_ff)
         2'd0:    gath_new[7:0]   = gather_ff[7:0]   | s1_byte_ff;
         2'd1:    gath_new[15:8]  = gather_ff[15:8]  | s1_byte_ff;
         2'd2:    gath_new[23:16] = gather_ff[23:16] | s1_byte_ff;
         default: gath_new = gather_ff;   // fourth byte of a 32bpp pixel: drop
      endcase
      idx_next = idx_ff + 2'd1;
      case (pixel_format_ff)
         FMT_16BPP: need = 3'd2;
         FMT_24BPP: need = 3'd3;
         default:   need = 3'd4;
      endcase
      complete = (idx_next == 2'd0) || ({1'b0, idx_next} >= need);
      g0 = gath_new[7:0];
      g1 = gath_new[15:8];
   end

   always_comb begin
      emit       = 1'b0;
      item_end   = 1'b1;
      gather_fmt = 1'b0;
      raw_color  = '0;
      case (pixel_format_ff)
         FMT_4BPP: begin
            emit      = 1'b1;
            raw_color = nibble_ff ? rd_lo_ff : rd_hi_ff;
            // the low nibble is dropped when the high one ends the image
            item_end  = nibble_ff | is_last;
         end
         FMT_8BPP: begin
            emit      = 1'b1;
            raw_color = s1_oob_ff ? '0 : rd_hi_ff;
         end
         FMT_16BPP: begin
            gather_fmt = 1'b1;
            emit       = complete;
            raw_color  = {g1 & 8'h1F, (g0 & 8'h07) | (g1 & 8'hE0), g0 & 8'hF8, 8'h00};
         end
         FMT_24BPP, FMT_32BPP: begin
            gather_fmt = 1'b1;
            emit       = complete;
            raw_color  = {gath_new, 8'h00};
         end
         default: ;   // undefined format: ignore the byte
      endcase
   end

   assign emit_fire = adv & emit;
   assign drop      = (key_mode_ff == KEY_SKIP) && (raw_color == key_color_ff);
   assign out_color = ((key_mode_ff == KEY_REPLACE) && (raw_color == key_color_ff)) ?
                      substitute_color_ff : raw_color;
   assign rsp_load  = emit_fire & ~drop;

   always_comb begin
      nibble_in = nibble_ff;
      gather_in = gather_ff;
      idx_in    = idx_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (adv) begin
         if (pixel_format_ff == FMT_4BPP) begin
            nibble_in = ~nibble_ff & ~is_last;
         end
         if (gather_fmt) begin
            if (complete) begin
               gather_in = '0;
               idx_in    = '0;
            end else begin
               gather_in = gath_new;
               idx_in    = idx_next;
            end
         end
      end
      if (emit_fire) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               // image end: restart position and byte assembly
               row_in    = '0;
               nibble_in = 1'b0;
               gather_in = '0;
               idx_in    = '0;
            end else begin
               row_in = row_inc[XY_W-1:0];
            end
         end else begin
            col_in = col_inc[XY_W-1:0];
         end
      end
   end

   // Take a new byte when the stage is empty or finishing its item now
   assign req_tready  = ~s1_valid_ff | (adv & item_end);
   assign s1_valid_in = (req_accept && req_tuser == CMD_PIXEL) ? 1'b1 :
                        (adv & item_end) ? 1'b0 : s1_valid_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         nibble_ff    <= 1'b0;
         gather_ff    <= '0;
         idx_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         nibble_ff    <= nibble_in;
         gather_ff    <= gather_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_color_ff <= out_color;
         rsp_x_ff     <= pix_x;
         rsp_y_ff     <= pix_y;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_y_ff, rsp_x_ff, rsp_color_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // The second nibble is only ever pending on a byte held in the stage
   assert property (@(posedge clock) disable iff (reset)
      nibble_ff |-> s1_valid_ff)
      else $error("nibble pending without a byte in the pixel stage");

   // The last position of an image restarts position and byte assembly
   assert property (@(posedge clock) disable iff (reset)
      (emit_fire && is_last) |=> (col_ff == '0 && row_ff == '0 && idx_ff == '0 && !nibble_ff))
      else $error("image end did not restart the counters");

   // A stalled result keeps the pixel stage occupied
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("pixel stage lost its item while the result stalled");
`endif

endmodule

### sim/tb_bmp_pixel_unpack_color_key.sv
// ----------------------------------------------------------------------------
// tb_bmp_pixel_unpack_color_key
// Self-checking bench for the BMP pixel unpacker with color key.
// ----------------------------------------------------------------------------
// The bench loads the whole palette first. It then runs a short directed
// pass over the field extremes, every pixel format and key mode, and the
// corner cases: the dropped low nibble at image end, skipped and replaced
// pixels, a format change in the middle of a gathered pixel, undefined
// formats and modes, and clamped dimensions. After that come random phases.
// Each phase writes a fresh register setting while the block is idle and
// then streams palette loads and pixel bytes, often with bytes chosen to
// hit the color key. Every accepted item runs through a bit-true decoder
// kept in the bench. Each pixel that comes out is checked field by field
// against the oldest pixel still due.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_unpack_color_key;
   import bmpuck_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 8;      // covers the two-stage pixel pipe
   localparam int ITEM_GOAL   = 1050;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  slot;
      logic [31:0] word;
      logic [7:0]  data;
   } bmp_item_type;

   typedef struct packed {
      logic [31:0] color;
      logic [10:0] x;
      logic [10:0] y;
      logic        last;
   } pixel_type;

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // palette_slot[7:0], palette_word[39:8], data_byte[47:40]
   logic        req_tuser = 1'b0;  // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // pixel_color[31:0], pixel_x[42:32], pixel_y[53:43], zero
   logic        rsp_tlast;         // last_pixel
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bmp_pixel_unpack_color_key DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Items waiting to be sent and pixels the decoder says must come out
   bmp_item_type bmp_items[$];
   pixel_type    pixels_due[$];

   // Bench copy of the block state and registers
   logic [31:0] pal_copy [256];
   logic [23:0] gathered = '0;
   logic [1:0]  gathered_n = '0;
   int unsigned col_cnt = 0;
   int unsigned row_cnt = 0;
   logic [2:0]  cfg_format = PIXEL_FORMAT_RST;
   logic [1:0]  cfg_key_mode = KEY_DRAW_ALL;
   logic [31:0] cfg_key_color = '0;
   logic [31:0] cfg_sub_color = '0;
   logic [9:0]  cfg_org_x = '0;
   logic [9:0]  cfg_org_y = '0;
   logic [10:0] cfg_width = IMAGE_DIM_RST;
   logic [10:0] cfg_height = IMAGE_DIM_RST;

   // Bookkeeping
   int unsigned queued = 0;
   int unsigned accepted = 0;
   int unsigned palette_loads = 0;
   int unsigned pixels_checked = 0;
   int unsigned key_hits = 0;
   int unsigned reg_writes = 0;
   int unsigned phases = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   // Driver state
   bmp_item_type   cur_item = '0;
   bit             item_taken = 1'b0;
   int unsigned    burst_left = 4;
   int unsigned    gap_left = 0;
   ready_mode_type rdy_mode = READY_ALWAYS;
   int unsigned    rdy_left = 0;

   // --------------------------------------------------------------------------
   // Decoder model
   // --------------------------------------------------------------------------
   function automatic int unsigned dim_of(input int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
   endfunction

   function automatic int unsigned bytes_per_pixel(input logic [2:0] f);
      case (f)
         FMT_16BPP: return 2;
         FMT_24BPP: return 3;
         FMT_32BPP: return 4;
         default:   return 0;
      endcase
   endfunction

   // 16bpp spreads two bytes over color bytes 1..3; wider formats shift in whole
   function automatic logic [31:0] gathered_color(input int unsigned need,
                                                  input logic [23:0] g);
      logic [7:0] b0, b1;
      b0 = g[7:0];
      b1 = g[15:8];
      if (need == 2)
         return {3'b000, b1[4:0], b1[7:5], 2'b00, b0[2:0], b0[7:3], 3'b000, 8'h00};
      return {g, 8'h00};
   endfunction

   // Place one pixel at the current position and advance; returns image end
   function automatic bit place_pixel(input logic [31:0] color);
      int unsigned w, h;
      pixel_type   p;
      bit          img_end;
      w = dim_of(cfg_width);
      h = dim_of(cfg_height);
      p.x = 11'(cfg_org_x + col_cnt);
      p.y = 11'(cfg_org_y + h - row_cnt);
      p.last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
      img_end = 1'b0;
      if (col_cnt + 1 >= w) begin
         col_cnt = 0;
         if (row_cnt + 1 >= h) begin
            row_cnt = 0;
            gathered = '0;
            gathered_n = '0;
            img_end = 1'b1;
         end else begin
            row_cnt = (row_cnt + 1) & 32'h7FF;
         end
      end else begin
         col_cnt = (col_cnt + 1) & 32'h7FF;
      end
      if (color == cfg_key_color && cfg_key_mode == KEY_SKIP) begin
         key_hits++;
         return img_end;
      end
      if (color == cfg_key_color && cfg_key_mode == KEY_REPLACE) begin
         key_hits++;
         color = cfg_sub_color;
      end
      p.color = color;
      pixels_due.push_back(p);
      return img_end;
   endfunction

   function automatic void decode_bmp_item(input bmp_item_type it);
      int unsigned need;
      if (it.cmd == CMD_PALETTE) begin
         pal_copy[it.slot] = it.word;
         return;
      end
      case (cfg_format)
         FMT_4BPP: begin
            // drop the low nibble when the high one closed the image
            if (!place_pixel(pal_copy[{4'h0, it.data[7:4]}]))
               void'(place_pixel(pal_copy[{4'h0, it.data[3:0]}]));
            return;
         end
         FMT_8BPP: begin
            void'(place_pixel(pal_copy[it.data]));
            return;
         end
         FMT_16BPP, FMT_24BPP, FMT_32BPP: need = bytes_per_pixel(cfg_format);
         default: return;
      endcase
      if (gathered_n < 3)
         gathered = gathered | (24'(it.data) << (8 * gathered_n));
      gathered_n = gathered_n + 2'd1;
      if (gathered_n != 0 && gathered_n < need) return;
      void'(place_pixel(gathered_color(need, gathered)));
      gathered = '0;
      gathered_n = '0;
   endfunction

   // --------------------------------------------------------------------------
   // Driver: send queued items in bursts, hold each until accepted
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !item_taken) begin
         // hold the item
      end else begin
         item_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (bmp_items.size() > 0) begin
            cur_item = bmp_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {cur_item.data, cur_item.word, cur_item.slot};
            req_tuser <= cur_item.cmd;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: stall on a pattern that is picked anew at random
   always @(negedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode = ready_mode_type'($urandom_range(0, 2));
         rdy_left = $urandom_range(10, 80);
      end else begin
         rdy_left--;
      end
      case (rdy_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // --------------------------------------------------------------------------
   // Monitor: predict on each accepted item, check each accepted pixel
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            decode_bmp_item(cur_item);
            accepted++;
            item_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pixels_due.size() == 0) begin
               $error("pixel with nothing due: color %h x %0d y %0d last %0d",
                      rsp_tdata[31:0], rsp_tdata[42:32], rsp_tdata[53:43], rsp_tlast);
               errors++;
            end else begin
               want = pixels_due.pop_front();
               pixels_checked++;
               if (rsp_tdata[31:0] !== want.color) begin
                  $error("pixel_color: expected %h, got %h", want.color, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[42:32] !== want.x) begin
                  $error("pixel_x: expected %0d, got %0d", want.x, rsp_tdata[42:32]);
                  errors++;
               end
               if (rsp_tdata[53:43] !== want.y) begin
                  $error("pixel_y: expected %0d, got %0d", want.y, rsp_tdata[53:43]);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_pixel: expected %0d, got %0d", want.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      bmp_item_type it;
      it.cmd = CMD_PIXEL;
      it.slot = 8'($urandom_range(0, 255));
      it.word = $urandom;
      it.data = b;
      bmp_items.push_back(it);
      queued++;
   endtask

   task automatic push_palette(input logic [7:0] slot, input logic [31:0] word);
      bmp_item_type it;
      it.cmd = CMD_PALETTE;
      it.slot = slot;
      it.word = word;
      it.data = 8'($urandom_range(0, 255));
      bmp_items.push_back(it);
      queued++;
      palette_loads++;
   endtask

   // Wait until every item is in and every due pixel is out, then let the
   // pipe empty of bytes that produce nothing
   task automatic wait_idle();
      do @(negedge clock); while (accepted != queued || pixels_due.size() != 0);
      repeat (DRAIN) @(negedge clock);
   endtask

   // Register write: setup cycle, access cycle, then release the bus
   task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_PIXEL_FORMAT:     cfg_format = val[2:0];
         REG_KEY_MODE:         cfg_key_mode = val[1:0];
         REG_KEY_COLOR:        cfg_key_color = val;
         REG_SUBSTITUTE_COLOR: cfg_sub_color = val;
         REG_ORIGIN_X:         cfg_org_x = val[9:0];
         REG_ORIGIN_Y:         cfg_org_y = val[9:0];
         REG_IMAGE_WIDTH:      cfg_width = val[10:0];
         default:              cfg_height = val[10:0];
      endcase
      reg_writes++;
   endtask

   function automatic logic [10:0] pick_dim();
      case ($urandom_range(0, 19))
         0:       return 11'd0;
         1:       return 11'd1024;
         2:       return 11'($urandom_range(1025, 2047));
         default: return 11'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [9:0] pick_origin();
      case ($urandom_range(0, 7))
         0:       return 10'd0;
         1:       return 10'd1023;
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // One random phase: new register setting, then a stream of items
   task automatic random_phase();
      logic [2:0]  f;
      logic [7:0]  key_slot;
      logic [7:0]  kb [3];
      logic [7:0]  b;
      logic [31:0] key;
      int unsigned n, count, need, k;
      bit          hit;

      f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      set_reg(REG_PIXEL_FORMAT, {29'd0, f});
      set_reg(REG_KEY_MODE, {30'd0, 2'($urandom_range(0, 3))});

      // aim the key at a color this format can actually produce
      need = bytes_per_pixel(f);
      key_slot = (f == FMT_4BPP) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      for (k = 0; k < 3; k++) kb[k] = 8'($urandom_range(0, 255));
      if (f == FMT_4BPP || f == FMT_8BPP) key = pal_copy[key_slot];
      else if (need != 0) key = gathered_color(need, {kb[2], kb[1], kb[0]});
      else key = $urandom;
      if ($urandom_range(0, 7) == 0) key = pick_word();
      set_reg(REG_KEY_COLOR, key);
      set_reg(REG_SUBSTITUTE_COLOR, pick_word());

      // leave position registers alone at times so images span phases
      if ($urandom_range(0, 1)) set_reg(REG_ORIGIN_X, {22'd0, pick_origin()});
      if ($urandom_range(0, 1)) set_reg(REG_ORIGIN_Y, {22'd0, pick_origin()});
      if ($urandom_range(0, 1)) set_reg(REG_IMAGE_WIDTH, {21'd0, pick_dim()});
      if ($urandom_range(0, 1)) set_reg(REG_IMAGE_HEIGHT, {21'd0, pick_dim()});

      n = $urandom_range(8, 48);
      count = 0;
      while (count < n) begin
         hit = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) begin
            push_palette(8'($urandom_range(0, 255)), pick_word());
            count++;
         end else if (need != 0) begin
            for (k = 0; k < need; k++)
               push_byte((hit && k < 3) ? kb[k] : 8'($urandom_range(0, 255)));
            count += need;
         end else begin
            b = 8'($urandom_range(0, 255));
            if (hit && f == FMT_4BPP) begin
               b[7:4] = key_slot[3:0];
               if ($urandom_range(0, 1)) b[3:0] = key_slot[3:0];
            end else if (hit && f == FMT_8BPP) begin
               b = key_slot;
            end
            push_byte(b);
            count++;
         end
      end

      // now and then leave a pixel half gathered for the next setting
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      phases++;
      wait_idle();
   endtask

   // --------------------------------------------------------------------------
   // Test sequence
   // --------------------------------------------------------------------------
   initial begin
      int unsigned i;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Load the whole palette, extremes of slot and word included
      for (i = 0; i < 256; i++) begin
         case (i)
            0:       push_palette(8'(i), 32'hFFFF_FFFF);
            15:      push_palette(8'(i), 32'hA5A5_A5A5);
            240:     push_palette(8'(i), 32'h5A5A_5A5A);
            255:     push_palette(8'(i), 32'h0000_0000);
            default: push_palette(8'(i), $urandom);
         endcase
      end
      wait_idle();

      // Reset setting, 16bpp on a 1x1 image: extreme bytes
      push_byte(8'hFF); push_byte(8'h00);
      push_byte(8'h00); push_byte(8'hFF);
      wait_idle();

      // 4bpp at the far corner; the third pixel ends the image mid-byte
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_4BPP});
      set_reg(REG_IMAGE_WIDTH, 32'd3);
      set_reg(REG_ORIGIN_X, 32'd1023);
      set_reg(REG_ORIGIN_Y, 32'd1023);
      push_byte(8'h0F);
      push_byte(8'hF0);
      wait_idle();

      // Skip mode: a skipped last pixel still closes the image
      set_reg(REG_IMAGE_WIDTH, 32'd2);
      set_reg(REG_KEY_MODE, {30'd0, KEY_SKIP});
      set_reg(REG_KEY_COLOR, 32'hFFFF_FFFF);
      push_byte(8'h00);
      push_byte(8'h0F);
      wait_idle();

      // 8bpp replace mode on a 2x2 image
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_8BPP});
      set_reg(REG_IMAGE_HEIGHT, 32'd2);
      set_reg(REG_ORIGIN_X, 32'd0);
      set_reg(REG_ORIGIN_Y, 32'd0);
      set_reg(REG_KEY_MODE, {30'd0, KEY_REPLACE});
      set_reg(REG_KEY_COLOR, 32'hA5A5_A5A5);
      set_reg(REG_SUBSTITUTE_COLOR, 32'h1234_5678);
      push_byte(8'h0F); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hF0);
      wait_idle();

      // Undefined key mode draws everything, key color included
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_24BPP});
      set_reg(REG_KEY_MODE, 32'd3);
      set_reg(REG_KEY_COLOR, 32'h3322_1100);
      push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
      wait_idle();

      // 32bpp drops the fourth byte
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_32BPP});
      push_byte(8'h44); push_byte(8'h55); push_byte(8'h66); push_byte(8'h77);
      wait_idle();

      // Format change inside a pixel keeps the bytes already gathered
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_24BPP});
      push_byte(8'hAB);
      wait_idle();
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_16BPP});
      push_byte(8'hCD);
      wait_idle();
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_32BPP});
      push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
      wait_idle();
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_24BPP});
      push_byte(8'h04);
      wait_idle();

      // Undefined format ignores the byte
      set_reg(REG_PIXEL_FORMAT, 32'd5);
      push_byte(8'h99);
      wait_idle();

      // Zero dimensions act as one, oversized ones clamp
      set_reg(REG_PIXEL_FORMAT, {29'd0, FMT_8BPP});
      set_reg(REG_IMAGE_WIDTH, 32'd0);
      set_reg(REG_IMAGE_HEIGHT, 32'd0);
      push_byte(8'h01);
      wait_idle();
      set_reg(REG_IMAGE_WIDTH, 32'd2047);
      set_reg(REG_IMAGE_HEIGHT, 32'd2047);
      push_byte(8'h02); push_byte(8'h03);
      wait_idle();

      // Random phases until the item budget is spent
      while (queued < ITEM_GOAL) random_phase();

      wait_idle();
      $display("Sent %0d items (%0d palette loads) over %0d random phases, %0d register writes.",
               accepted, palette_loads, phases, reg_writes);
      $display("Checked %0d pixels; %0d decoded colors matched the key.",
               pixels_checked, key_hits);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
